FILE: hw/rtl/gbr_pkg.sv
`default_nettype none
package gbr_pkg;

   localparam int KERNEL_RADIUS = 5;
   localparam int MAX_WIDTH     = 1024;
   localparam int MAX_HEIGHT    = 4096;
   localparam int RING_ROWS     = 2 * KERNEL_RADIUS + 1;
   localparam int NUM_COEF      = 6;
   localparam int COL_W         = $clog2(MAX_WIDTH);
   localparam int ROW_W         = $clog2(MAX_HEIGHT);
   localparam int SLOT_W        = $clog2(RING_ROWS);
   localparam int TAP_W         = $clog2(RING_ROWS);
   localparam int ADDR_W        = SLOT_W + COL_W;
   localparam int CH_W          = 8;
   localparam int PIX_W         = 3 * CH_W;
   localparam int COEF_W        = 16;
   localparam int WT_W          = 2 * COEF_W;
   localparam int PROD_W        = CH_W + WT_W;
   localparam int ACC_W         = PROD_W + 8;
   localparam int MOD_SHIFT     = 16;
   localparam int MOD_RECIP     = ((1 << MOD_SHIFT) + RING_ROWS - 1) / RING_ROWS;
   localparam int CSR_IDX_W     = 3;
   localparam int CSR_DATA_W    = 16;
   localparam int WIDTH_REG_W   = 11;
   localparam int HEIGHT_REG_W  = 13;

   localparam logic [CSR_IDX_W-1:0] CSR_IMAGE_WIDTH  = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_IMAGE_HEIGHT = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_COEF_CENTER  = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_COEF_OFF1    = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_COEF_OFF2    = 3'd4;
   localparam logic [CSR_IDX_W-1:0] CSR_COEF_OFF3    = 3'd5;
   localparam logic [CSR_IDX_W-1:0] CSR_COEF_OFF4    = 3'd6;
   localparam logic [CSR_IDX_W-1:0] CSR_COEF_OFF5    = 3'd7;

   typedef struct packed {
      logic [COL_W-1:0]                  wm1;
      logic [ROW_W-1:0]                  hm1;
      logic [NUM_COEF-1:0][COEF_W-1:0]   coef;
   } cfg_type;

   typedef struct packed {
      logic [PIX_W-1:0]  pix;
      logic [SLOT_W-1:0] slot;
      logic [COL_W-1:0]  col;
      logic [ROW_W-1:0]  r0;
      logic [ROW_W-1:0]  r1;
      logic [COL_W-1:0]  c0;
      logic [COL_W-1:0]  c1;
      logic              has_out;
   } job_type;

   typedef struct packed {
      logic [CH_W-1:0]  red;
      logic [CH_W-1:0]  green;
      logic [CH_W-1:0]  blue;
      logic [ROW_W-1:0] row;
      logic [COL_W-1:0] col;
      logic             last_of_run;
      logic             frame_done;
   } rsp_type;

   // Weight of one kernel tap along one axis; offsets without a register weigh zero.
   function automatic logic [COEF_W-1:0] tap_weight(
      input logic [NUM_COEF-1:0][COEF_W-1:0] coef,
      input logic [TAP_W-1:0]                idx
   );
      logic [TAP_W-1:0] off;
      off = (idx >= TAP_W'(KERNEL_RADIUS)) ? idx - TAP_W'(KERNEL_RADIUS)
                                           : TAP_W'(KERNEL_RADIUS) - idx;
      if (off < TAP_W'(NUM_COEF)) begin
         tap_weight = coef[off];
      end else begin
         tap_weight = '0;
      end
   endfunction

   // Row number modulo the ring depth, by reciprocal multiplication.
   function automatic logic [SLOT_W-1:0] ring_slot(input logic [ROW_W:0] x);
      logic [ROW_W+MOD_SHIFT:0] prod;
      logic [ROW_W:0]           q;
      logic [ROW_W:0]           rem;
      prod = (ROW_W+MOD_SHIFT+1)'(x) * (ROW_W+MOD_SHIFT+1)'(MOD_RECIP);
      q    = prod[ROW_W+MOD_SHIFT:MOD_SHIFT];
      rem  = x - (ROW_W+1)'(q * (ROW_W+1)'(RING_ROWS));
      ring_slot = rem[SLOT_W-1:0];
   endfunction

endpackage
`default_nettype wire

FILE: hw/rtl/gbr_front.sv
`default_nettype none
module gbr_front (
   input  wire logic              clock,
   input  wire logic              reset,
   input  gbr_pkg::cfg_type       cfg,
   input  wire logic              req_push,
   input  wire logic [7:0]        req_red,
   input  wire logic [7:0]        req_green,
   input  wire logic [7:0]        req_blue,
   input  wire logic              q_full,
   output logic                   q_push,
   output gbr_pkg::job_type       q_job
);

   logic [gbr_pkg::ROW_W-1:0]  row_ff, row_in;
   logic [gbr_pkg::COL_W-1:0]  col_ff, col_in;
   logic [gbr_pkg::SLOT_W-1:0] slot_ff, slot_in;

   logic                        wrap_col;
   logic [gbr_pkg::ROW_W:0]     r_tmp;
   logic [gbr_pkg::ROW_W-1:0]   r_cur;
   logic [gbr_pkg::COL_W-1:0]   c_cur;
   logic [gbr_pkg::SLOT_W-1:0]  s_tmp, s_cur, s_next;
   logic [gbr_pkg::COL_W:0]     c_inc;
   logic [gbr_pkg::ROW_W:0]     r_inc;
   logic                        last_row, last_col;

   assign q_push = req_push && !q_full;

   always_comb begin
      // Normalize a position left beyond the frame by a register change.
      wrap_col = col_ff > cfg.wm1;
      c_cur    = wrap_col ? '0 : col_ff;
      r_tmp    = {1'b0, row_ff} + (gbr_pkg::ROW_W+1)'(wrap_col);
      s_tmp    = slot_ff;
      if (wrap_col) begin
         s_tmp = (slot_ff == gbr_pkg::SLOT_W'(gbr_pkg::RING_ROWS - 1)) ? '0 : slot_ff + 1'b1;
      end
      if (r_tmp > {1'b0, cfg.hm1}) begin
         r_cur = '0;
         s_cur = '0;
      end else begin
         r_cur = r_tmp[gbr_pkg::ROW_W-1:0];
         s_cur = s_tmp;
      end
      s_next = (s_cur == gbr_pkg::SLOT_W'(gbr_pkg::RING_ROWS - 1)) ? '0 : s_cur + 1'b1;

      last_row = r_cur == cfg.hm1;
      last_col = c_cur == cfg.wm1;

      q_job.pix  = {req_red, req_green, req_blue};
      q_job.slot = s_cur;
      q_job.col  = c_cur;
      q_job.r0   = (r_cur < gbr_pkg::ROW_W'(gbr_pkg::KERNEL_RADIUS)) ? '0
                   : r_cur - gbr_pkg::ROW_W'(gbr_pkg::KERNEL_RADIUS);
      q_job.r1   = last_row ? cfg.hm1 : q_job.r0;
      q_job.c0   = (c_cur < gbr_pkg::COL_W'(gbr_pkg::KERNEL_RADIUS)) ? '0
                   : c_cur - gbr_pkg::COL_W'(gbr_pkg::KERNEL_RADIUS);
      q_job.c1   = last_col ? cfg.wm1 : q_job.c0;
      q_job.has_out = (last_row || r_cur >= gbr_pkg::ROW_W'(gbr_pkg::KERNEL_RADIUS)) &&
                      (last_col || c_cur >= gbr_pkg::COL_W'(gbr_pkg::KERNEL_RADIUS));

      // Advance to the next raster position.
      c_inc  = {1'b0, c_cur} + 1'b1;
      r_inc  = {1'b0, r_cur} + 1'b1;
      row_in = r_cur;
      col_in = c_inc[gbr_pkg::COL_W-1:0];
      slot_in = s_cur;
      if (c_inc > {1'b0, cfg.wm1}) begin
         col_in = '0;
         if (r_inc > {1'b0, cfg.hm1}) begin
            row_in  = '0;
            slot_in = '0;
         end else begin
            row_in  = r_inc[gbr_pkg::ROW_W-1:0];
            slot_in = s_next;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         row_ff  <= '0;
         col_ff  <= '0;
         slot_ff <= '0;
      end else if (q_push) begin
         row_ff  <= row_in;
         col_ff  <= col_in;
         slot_ff <= slot_in;
      end
   end

endmodule
`default_nettype wire

FILE: hw/rtl/gbr_jobq.sv
`default_nettype none
module gbr_jobq (
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire logic         push,
   input  gbr_pkg::job_type  job_in,
   output logic              full,
   input  wire logic         pop,
   output gbr_pkg::job_type  job_out,
   output logic              empty
);

   gbr_pkg::job_type entry_ff [2];
   logic       wp_ff, rp_ff;
   logic [1:0] cnt_ff;

   assign full    = cnt_ff == 2'd2;
   assign empty   = cnt_ff == 2'd0;
   assign job_out = entry_ff[rp_ff];

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wp_ff] <= job_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wp_ff  <= 1'b0;
         rp_ff  <= 1'b0;
         cnt_ff <= '0;
      end else begin
         if (push) begin
            wp_ff <= ~wp_ff;
         end
         if (pop) begin
            rp_ff <= ~rp_ff;
         end
         cnt_ff <= cnt_ff + 2'(push) - 2'(pop);
      end
   end

endmodule
`default_nettype wire

FILE: hw/rtl/gbr_back.sv
`default_nettype none
module gbr_back (
   input  wire logic         clock,
   input  wire logic         reset,
   input  gbr_pkg::cfg_type  cfg,
   input  wire logic         q_empty,
   output logic              q_pop,
   input  gbr_pkg::job_type  q_job,
   input  wire logic         rsp_pop,
   output logic              rsp_empty,
   output gbr_pkg::rsp_type  rsp_data
);

   typedef enum logic [3:0] {
      B_IDLE  = 4'b0001,
      B_WAIT  = 4'b0010,
      B_TAPS  = 4'b0100,
      B_DRAIN = 4'b1000
   } back_state_type;

   localparam int TAPS = gbr_pkg::RING_ROWS;
   localparam int OQ_DEPTH = 4;

   back_state_type state_ff, state_in;
   gbr_pkg::job_type job_ff;
   logic [gbr_pkg::ROW_W-1:0] orow_ff, orow_in;
   logic [gbr_pkg::COL_W-1:0] ocol_ff, ocol_in;
   logic [gbr_pkg::TAP_W-1:0] ti_ff, ti_in, tj_ff, tj_in;

   logic [gbr_pkg::PIX_W-1:0] line_store [gbr_pkg::RING_ROWS * gbr_pkg::MAX_WIDTH];

   logic                          v1_ff, l1_ff, v2_ff, l2_ff, v3_ff, l3_ff, done_ff;
   logic [gbr_pkg::ROW_W-1:0]     rr_ff;
   logic [gbr_pkg::COL_W-1:0]     cc_ff;
   logic [gbr_pkg::COEF_W-1:0]    wr_ff, wc_ff;
   logic [gbr_pkg::PIX_W-1:0]     pix_ff;
   logic [gbr_pkg::WT_W-1:0]      wt_ff;
   logic [2:0][gbr_pkg::PROD_W-1:0] prod_ff;
   logic [2:0][gbr_pkg::ACC_W-1:0]  acc_ff;

   gbr_pkg::rsp_type oq_ff [OQ_DEPTH];
   logic [1:0] oq_wp_ff, oq_rp_ff;
   logic [2:0] oq_cnt_ff;

   logic start, issue, tap_last, push;
   logic signed [gbr_pkg::ROW_W+1:0] rr_s;
   logic signed [gbr_pkg::COL_W+1:0] cc_s;
   logic [gbr_pkg::ROW_W-1:0] rr_c;
   logic [gbr_pkg::COL_W-1:0] cc_c;
   logic [gbr_pkg::ADDR_W-1:0] rd_addr;
   gbr_pkg::rsp_type result;

   assign q_pop     = (state_ff == B_IDLE) && !q_empty;
   assign start     = (state_ff == B_WAIT) && (oq_cnt_ff < 3'(OQ_DEPTH));
   assign issue     = state_ff == B_TAPS;
   assign tap_last  = (ti_ff == gbr_pkg::TAP_W'(TAPS - 1)) && (tj_ff == gbr_pkg::TAP_W'(TAPS - 1));
   assign push      = (state_ff == B_DRAIN) && done_ff;
   assign rsp_empty = oq_cnt_ff == 3'd0;
   assign rsp_data  = oq_ff[oq_rp_ff];
   assign rd_addr   = {gbr_pkg::ring_slot({1'b0, rr_ff}), cc_ff};

   always_comb begin
      rr_s = $signed({2'b00, orow_ff}) + $signed((gbr_pkg::ROW_W+2)'(ti_ff))
             - $signed((gbr_pkg::ROW_W+2)'(gbr_pkg::KERNEL_RADIUS));
      cc_s = $signed({2'b00, ocol_ff}) + $signed((gbr_pkg::COL_W+2)'(tj_ff))
             - $signed((gbr_pkg::COL_W+2)'(gbr_pkg::KERNEL_RADIUS));
      if (rr_s < 0) begin
         rr_c = '0;
      end else if (rr_s > $signed({2'b00, cfg.hm1})) begin
         rr_c = cfg.hm1;
      end else begin
         rr_c = rr_s[gbr_pkg::ROW_W-1:0];
      end
      if (cc_s < 0) begin
         cc_c = '0;
      end else if (cc_s > $signed({2'b00, cfg.wm1})) begin
         cc_c = cfg.wm1;
      end else begin
         cc_c = cc_s[gbr_pkg::COL_W-1:0];
      end
   end

   always_comb begin
      state_in = state_ff;
      orow_in  = orow_ff;
      ocol_in  = ocol_ff;
      ti_in    = ti_ff;
      tj_in    = tj_ff;
      case (state_ff)
         B_IDLE: begin
            if (!q_empty && q_job.has_out) begin
               orow_in  = q_job.r0;
               ocol_in  = q_job.c0;
               state_in = B_WAIT;
            end
         end
         B_WAIT: begin
            if (start) begin
               ti_in    = '0;
               tj_in    = '0;
               state_in = B_TAPS;
            end
         end
         B_TAPS: begin
            if (tj_ff == gbr_pkg::TAP_W'(TAPS - 1)) begin
               tj_in = '0;
               ti_in = ti_ff + 1'b1;
            end else begin
               tj_in = tj_ff + 1'b1;
            end
            if (tap_last) begin
               state_in = B_DRAIN;
            end
         end
         B_DRAIN: begin
            if (done_ff) begin
               if (ocol_ff != job_ff.c1) begin
                  ocol_in  = ocol_ff + 1'b1;
                  state_in = B_WAIT;
               end else if (orow_ff != job_ff.r1) begin
                  orow_in  = orow_ff + 1'b1;
                  ocol_in  = job_ff.c0;
                  state_in = B_WAIT;
               end else begin
                  state_in = B_IDLE;
               end
            end
         end
         default: begin
            state_in = B_IDLE;
         end
      endcase
   end

   always_comb begin
      result.red   = (acc_ff[0][gbr_pkg::ACC_W-1:gbr_pkg::WT_W] > 16'd255) ? 8'hFF
                     : acc_ff[0][gbr_pkg::WT_W +: gbr_pkg::CH_W];
      result.green = (acc_ff[1][gbr_pkg::ACC_W-1:gbr_pkg::WT_W] > 16'd255) ? 8'hFF
                     : acc_ff[1][gbr_pkg::WT_W +: gbr_pkg::CH_W];
      result.blue  = (acc_ff[2][gbr_pkg::ACC_W-1:gbr_pkg::WT_W] > 16'd255) ? 8'hFF
                     : acc_ff[2][gbr_pkg::WT_W +: gbr_pkg::CH_W];
      result.row   = orow_ff;
      result.col   = ocol_ff;
      result.last_of_run = (orow_ff == job_ff.r1) && (ocol_ff == job_ff.c1);
      result.frame_done  = (orow_ff == cfg.hm1) && (ocol_ff == cfg.wm1);
   end

   // Line store: written when a job is taken, read one tap per cycle.
   always_ff @(posedge clock) begin
      if (q_pop) begin
         line_store[{q_job.slot, q_job.col}] <= q_job.pix;
      end
      pix_ff <= line_store[rd_addr];
   end

   always_ff @(posedge clock) begin
      if (q_pop) begin
         job_ff <= q_job;
      end
      rr_ff   <= rr_c;
      cc_ff   <= cc_c;
      wr_ff   <= gbr_pkg::tap_weight(cfg.coef, ti_ff);
      wc_ff   <= gbr_pkg::tap_weight(cfg.coef, tj_ff);
      wt_ff   <= wr_ff * wc_ff;
      prod_ff[0] <= gbr_pkg::PROD_W'(pix_ff[16 +: 8]) * gbr_pkg::PROD_W'(wt_ff);
      prod_ff[1] <= gbr_pkg::PROD_W'(pix_ff[8 +: 8])  * gbr_pkg::PROD_W'(wt_ff);
      prod_ff[2] <= gbr_pkg::PROD_W'(pix_ff[0 +: 8])  * gbr_pkg::PROD_W'(wt_ff);
      if (start) begin
         acc_ff <= '0;
      end else if (v3_ff) begin
         acc_ff[0] <= acc_ff[0] + gbr_pkg::ACC_W'(prod_ff[0]);
         acc_ff[1] <= acc_ff[1] + gbr_pkg::ACC_W'(prod_ff[1]);
         acc_ff[2] <= acc_ff[2] + gbr_pkg::ACC_W'(prod_ff[2]);
      end
      if (push) begin
         oq_ff[oq_wp_ff] <= result;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= B_IDLE;
         orow_ff   <= '0;
         ocol_ff   <= '0;
         ti_ff     <= '0;
         tj_ff     <= '0;
         v1_ff     <= 1'b0;
         l1_ff     <= 1'b0;
         v2_ff     <= 1'b0;
         l2_ff     <= 1'b0;
         v3_ff     <= 1'b0;
         l3_ff     <= 1'b0;
         done_ff   <= 1'b0;
         oq_wp_ff  <= '0;
         oq_rp_ff  <= '0;
         oq_cnt_ff <= '0;
      end else begin
         state_ff <= state_in;
         orow_ff  <= orow_in;
         ocol_ff  <= ocol_in;
         ti_ff    <= ti_in;
         tj_ff    <= tj_in;
         v1_ff    <= issue;
         l1_ff    <= issue && tap_last;
         v2_ff    <= v1_ff;
         l2_ff    <= l1_ff;
         v3_ff    <= v2_ff;
         l3_ff    <= l2_ff;
         if (start) begin
            done_ff <= 1'b0;
         end else if (v3_ff && l3_ff) begin
            done_ff <= 1'b1;
         end
         if (push) begin
            oq_wp_ff <= oq_wp_ff + 1'b1;
         end
         if (rsp_pop && !rsp_empty) begin
            oq_rp_ff <= oq_rp_ff + 1'b1;
         end
         oq_cnt_ff <= oq_cnt_ff + 3'(push) - 3'(rsp_pop && !rsp_empty);
      end
   end

endmodule
`default_nettype wire

FILE: hw/rtl/gaussian_blur_rgb_clamped.sv
// Each result is worked out in turn in the single tap unit, one line-store read and
// one weighted add per tap; a beat that completes no window is only written to the line store.
// Reset is synchronous and active high: it clears the raster position, both queues
// and the configuration registers to their defaults; the line store keeps its contents.
`default_nettype none
module gaussian_blur_rgb_clamped (
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire logic         req_push,
   output logic              req_full,
   input  wire logic [7:0]   req_red,
   input  wire logic [7:0]   req_green,
   input  wire logic [7:0]   req_blue,
   output logic              rsp_empty,
   input  wire logic         rsp_pop,
   output logic [7:0]        rsp_out_red,
   output logic [7:0]        rsp_out_green,
   output logic [7:0]        rsp_out_blue,
   output logic [11:0]       rsp_out_row,
   output logic [9:0]        rsp_out_col,
   output logic              rsp_last_of_run,
   output logic              rsp_frame_done,
   input  wire logic         csr_wr_en,
   input  wire logic [2:0]   csr_index,
   input  wire logic [15:0]  csr_wdata
);

   // Register file. Width and height are kept raw and clamped to the legal range
   // below, so a zero or oversized value behaves like the nearest legal one.
   logic [gbr_pkg::WIDTH_REG_W-1:0]  width_ff;
   logic [gbr_pkg::HEIGHT_REG_W-1:0] height_ff;
   logic [gbr_pkg::NUM_COEF-1:0][gbr_pkg::COEF_W-1:0] coef_ff;
   gbr_pkg::cfg_type cfg;

   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff   <= gbr_pkg::WIDTH_REG_W'(1024);
         height_ff  <= gbr_pkg::HEIGHT_REG_W'(768);
         coef_ff[0] <= 16'd9326;
         coef_ff[1] <= 16'd8822;
         coef_ff[2] <= 16'd7467;
         coef_ff[3] <= 16'd5656;
         coef_ff[4] <= 16'd3834;
         coef_ff[5] <= 16'd2326;
      end else if (csr_wr_en) begin
         case (csr_index)
            gbr_pkg::CSR_IMAGE_WIDTH:  width_ff   <= csr_wdata[gbr_pkg::WIDTH_REG_W-1:0];
            gbr_pkg::CSR_IMAGE_HEIGHT: height_ff  <= csr_wdata[gbr_pkg::HEIGHT_REG_W-1:0];
            gbr_pkg::CSR_COEF_CENTER:  coef_ff[0] <= csr_wdata;
            gbr_pkg::CSR_COEF_OFF1:    coef_ff[1] <= csr_wdata;
            gbr_pkg::CSR_COEF_OFF2:    coef_ff[2] <= csr_wdata;
            gbr_pkg::CSR_COEF_OFF3:    coef_ff[3] <= csr_wdata;
            gbr_pkg::CSR_COEF_OFF4:    coef_ff[4] <= csr_wdata;
            gbr_pkg::CSR_COEF_OFF5:    coef_ff[5] <= csr_wdata;
            default: begin
            end
         endcase
      end
   end

   // The datapath works with the last legal column and row index.
   always_comb begin
      if (width_ff == '0) begin
         cfg.wm1 = '0;
      end else if (width_ff > gbr_pkg::WIDTH_REG_W'(gbr_pkg::MAX_WIDTH)) begin
         cfg.wm1 = gbr_pkg::COL_W'(gbr_pkg::MAX_WIDTH - 1);
      end else begin
         cfg.wm1 = gbr_pkg::COL_W'(width_ff - 1'b1);
      end
      if (height_ff == '0) begin
         cfg.hm1 = '0;
      end else if (height_ff > gbr_pkg::HEIGHT_REG_W'(gbr_pkg::MAX_HEIGHT)) begin
         cfg.hm1 = gbr_pkg::ROW_W'(gbr_pkg::MAX_HEIGHT - 1);
      end else begin
         cfg.hm1 = gbr_pkg::ROW_W'(height_ff - 1'b1);
      end
      cfg.coef = coef_ff;
   end

   // The front end tracks the raster position and turns each beat into a job:
   // the pixel, where it lands in the ring, and the span of output pixels that
   // this beat completes. The short job queue lets the front keep taking beats
   // while the back end grinds through a multi-result flush at a frame edge.
   gbr_pkg::job_type front_job, back_job;
   gbr_pkg::rsp_type rsp_data;
   logic front_push, q_full, q_empty, q_pop;

   gbr_front u_front (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg),
      .req_push  (req_push),
      .req_red   (req_red),
      .req_green (req_green),
      .req_blue  (req_blue),
      .q_full    (q_full),
      .q_push    (front_push),
      .q_job     (front_job)
   );

   gbr_jobq u_jobq (
      .clock   (clock),
      .reset   (reset),
      .push    (front_push),
      .job_in  (front_job),
      .full    (q_full),
      .pop     (q_pop),
      .job_out (back_job),
      .empty   (q_empty)
   );

   // The back end writes the pixel into the line store when it takes the job, so
   // the store is always updated in beat order, and then walks every tap of each
   // output window through a pipelined multiply-accumulate unit. Finished results
   // wait in a small output queue.
   gbr_back u_back (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg),
      .q_empty   (q_empty),
      .q_pop     (q_pop),
      .q_job     (back_job),
      .rsp_pop   (rsp_pop),
      .rsp_empty (rsp_empty),
      .rsp_data  (rsp_data)
   );

   assign req_full        = q_full;
   assign rsp_out_red     = rsp_data.red;
   assign rsp_out_green   = rsp_data.green;
   assign rsp_out_blue    = rsp_data.blue;
   assign rsp_out_row     = rsp_data.row;
   assign rsp_out_col     = rsp_data.col;
   assign rsp_last_of_run = rsp_data.last_of_run;
   assign rsp_frame_done  = rsp_data.frame_done;

`ifndef SYNTHESIS
   // The bottom-right pixel is always the final result of the beat that flushes it.
   a_frame_done_is_last: assert property (@(posedge clock) disable iff (reset)
      (!rsp_empty && rsp_frame_done) |-> rsp_last_of_run)
      else $error("frame_done without last_of_run");

   // Results never name a position outside the frame.
   a_col_in_frame: assert property (@(posedge clock) disable iff (reset)
      !rsp_empty |-> (rsp_out_col <= cfg.wm1))
      else $error("result column beyond frame");

   a_row_in_frame: assert property (@(posedge clock) disable iff (reset)
      !rsp_empty |-> (rsp_out_row <= cfg.hm1))
      else $error("result row beyond frame");
`endif

endmodule
`default_nettype wire
